>>> hw/rtl/csg_pkg.sv
// Shared types and constants for the CAN signal to gauge step converter.
package csg_pkg;

    // Field widths of the stream payloads and configuration registers
    localparam int ID_W       = 32;
    localparam int LEN_W      = 4;
    localparam int PAYLOAD_W  = 64;
    localparam int TARGET_W   = 10;
    localparam int MOVE_W     = 11;
    localparam int ANGLE_W    = 9;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 72;   // msg_len + payload, padded to whole bytes
    localparam int M_TDATA_W  = 24;   // target_step + step_move, padded to whole bytes

    // Shared divider: unsigned numerator below den * 2**DIV_QW
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_QW    = 16;
    localparam int DIV_CNT_W = 4;

    // Scale constants
    localparam int HUNDREDTHS  = 100;
    localparam int DEG_PER_REV = 360;
    localparam int TGT_DIVISOR = DEG_PER_REV * HUNDREDTHS;
    localparam int TGT_ROUND   = TGT_DIVISOR / 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_START  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q16     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN_H  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX_H  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMITS = 3'd7;

    typedef struct packed {
        logic        [31:0] frame_id;
        logic        [5:0]  field_start;
        logic        [4:0]  field_width;
        logic signed [31:0] gain_q16;
        logic signed [15:0] value_offset;
        logic signed [31:0] value_min_h;
        logic signed [31:0] value_max_h;
        logic        [17:0] angle_limits;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EXTRACT,
        ST_MUL,
        ST_ADD,
        ST_ABS,
        ST_SCALE,
        ST_SIGN,
        ST_CLAMP,
        ST_SPAN,
        ST_NUM,
        ST_NABS,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_MAP,
        ST_TSCALE,
        ST_DIV2_GO,
        ST_DIV2_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_EXTRACT,
        OP_MUL,
        OP_ADD,
        OP_ABS,
        OP_SCALE,
        OP_SIGN,
        OP_CLAMP,
        OP_SPAN,
        OP_NUM,
        OP_NABS,
        OP_DIV1_START,
        OP_MAP,
        OP_TSCALE,
        OP_DIV2_START,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic match;
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

>>> hw/rtl/csg_div.sv
// Restoring divider, one quotient bit per cycle, shared by the angle map and the step rounding.
module csg_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [csg_pkg::DIV_NUM_W-1:0]   num,
    input  logic [csg_pkg::DIV_DEN_W-1:0]   den,
    output logic                            busy,
    output logic [csg_pkg::DIV_QW-1:0]      quo
);

    logic                            busy_reg, busy_next;
    logic [csg_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [csg_pkg::DIV_DEN_W-1:0]   rem_reg, rem_next;
    logic [csg_pkg::DIV_DEN_W-1:0]   den_reg, den_next;
    logic [csg_pkg::DIV_QW-1:0]      qb_reg, qb_next;
    logic [csg_pkg::DIV_DEN_W:0]     rem_sh;
    logic                            ge;

    assign rem_sh = {rem_reg, qb_reg[csg_pkg::DIV_QW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        qb_next   = qb_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = num[csg_pkg::DIV_NUM_W-1:csg_pkg::DIV_QW];
            den_next  = den;
            qb_next   = num[csg_pkg::DIV_QW-1:0];
        end else if (busy_reg) begin
            // Shift the next numerator bit in; quotient bits fill from the bottom
            rem_next = ge ? csg_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_reg})
                          : rem_sh[csg_pkg::DIV_DEN_W-1:0];
            qb_next  = {qb_reg[csg_pkg::DIV_QW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == csg_pkg::DIV_CNT_W'(csg_pkg::DIV_QW - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        qb_reg  <= qb_next;
    end

    assign busy = busy_reg;
    assign quo  = qb_reg;

endmodule

>>> hw/rtl/csg_ctrl.sv
// Sequencer that steps the datapath through decode, scale, map and step rounding.
module csg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  csg_pkg::status_t  stat,
    output csg_pkg::op_t      op
);

    csg_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            csg_pkg::ST_IDLE:      if (s_tvalid) state_next = csg_pkg::ST_CHECK;
            csg_pkg::ST_CHECK:     state_next = stat.match ? csg_pkg::ST_EXTRACT
                                                           : csg_pkg::ST_IDLE;
            csg_pkg::ST_EXTRACT:   state_next = csg_pkg::ST_MUL;
            csg_pkg::ST_MUL:       state_next = csg_pkg::ST_ADD;
            csg_pkg::ST_ADD:       state_next = csg_pkg::ST_ABS;
            csg_pkg::ST_ABS:       state_next = csg_pkg::ST_SCALE;
            csg_pkg::ST_SCALE:     state_next = csg_pkg::ST_SIGN;
            csg_pkg::ST_SIGN:      state_next = csg_pkg::ST_CLAMP;
            csg_pkg::ST_CLAMP:     state_next = csg_pkg::ST_SPAN;
            csg_pkg::ST_SPAN:      state_next = csg_pkg::ST_NUM;
            csg_pkg::ST_NUM:       state_next = csg_pkg::ST_NABS;
            csg_pkg::ST_NABS:      state_next = csg_pkg::ST_DIV1_GO;
            csg_pkg::ST_DIV1_GO:   state_next = csg_pkg::ST_DIV1_WAIT;
            csg_pkg::ST_DIV1_WAIT: if (!stat.div_busy) state_next = csg_pkg::ST_MAP;
            csg_pkg::ST_MAP:       state_next = csg_pkg::ST_TSCALE;
            csg_pkg::ST_TSCALE:    state_next = csg_pkg::ST_DIV2_GO;
            csg_pkg::ST_DIV2_GO:   state_next = csg_pkg::ST_DIV2_WAIT;
            csg_pkg::ST_DIV2_WAIT: if (!stat.div_busy) state_next = csg_pkg::ST_FINISH;
            csg_pkg::ST_FINISH:    if (stat.out_free) state_next = csg_pkg::ST_IDLE;
            default:               state_next = csg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        op       = csg_pkg::OP_NONE;
        case (state_reg)
            csg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) op = csg_pkg::OP_LOAD;
            end
            csg_pkg::ST_EXTRACT: op = csg_pkg::OP_EXTRACT;
            csg_pkg::ST_MUL:     op = csg_pkg::OP_MUL;
            csg_pkg::ST_ADD:     op = csg_pkg::OP_ADD;
            csg_pkg::ST_ABS:     op = csg_pkg::OP_ABS;
            csg_pkg::ST_SCALE:   op = csg_pkg::OP_SCALE;
            csg_pkg::ST_SIGN:    op = csg_pkg::OP_SIGN;
            csg_pkg::ST_CLAMP:   op = csg_pkg::OP_CLAMP;
            csg_pkg::ST_SPAN:    op = csg_pkg::OP_SPAN;
            csg_pkg::ST_NUM:     op = csg_pkg::OP_NUM;
            csg_pkg::ST_NABS:    op = csg_pkg::OP_NABS;
            csg_pkg::ST_DIV1_GO: op = csg_pkg::OP_DIV1_START;
            csg_pkg::ST_MAP:     op = csg_pkg::OP_MAP;
            csg_pkg::ST_TSCALE:  op = csg_pkg::OP_TSCALE;
            csg_pkg::ST_DIV2_GO: op = csg_pkg::OP_DIV2_START;
            csg_pkg::ST_FINISH:  if (stat.out_free) op = csg_pkg::OP_FINISH;
            default:             op = csg_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/csg_dpath.sv
// Datapath: field extraction, Q16.16 scaling, clamp, angle map, step target and output beat.
module csg_dpath #(
    parameter int FULL_SCALE_STEPS = 630,
    parameter int MAX_ANGLE        = 315,
    parameter int STEPS_PER_REV    = 720
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  csg_pkg::op_t                      op,
    input  csg_pkg::cfg_t                     cfg,
    input  logic [csg_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [csg_pkg::ID_W-1:0]          s_tuser,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [csg_pkg::M_TDATA_W-1:0]     m_tdata,
    output csg_pkg::status_t                  stat
);

    // Stage registers
    logic                                 match_reg;
    logic [csg_pkg::PAYLOAD_W-1:0]        word_reg;
    logic signed [31:0]                   val_reg;
    logic signed [63:0]                   prod_reg;
    logic signed [63:0]                   p_reg;
    logic [63:0]                          pabs_reg;
    logic                                 pneg_reg;
    logic [54:0]                          hmag_reg;
    logic signed [55:0]                   h_reg;
    logic signed [31:0]                   hc_reg;
    logic signed [32:0]                   diff_reg;
    logic signed [16:0]                   span_reg;
    logic signed [32:0]                   dsub_reg;
    logic                                 eq_reg;
    logic signed [49:0]                   num_reg;
    logic [csg_pkg::DIV_DEN_W-1:0]        dmag_reg;
    logic                                 dneg_reg;
    logic [csg_pkg::DIV_NUM_W-1:0]        nmag_reg;
    logic                                 qneg_reg;
    logic signed [17:0]                   a_reg;
    logic                                 azero_reg;
    logic [31:0]                          tnum_reg;
    logic [csg_pkg::TARGET_W-1:0]         needle_reg;
    logic                                 m_tvalid_reg, m_tvalid_next;
    logic [csg_pkg::TARGET_W-1:0]         tgt_out_reg;
    logic [csg_pkg::MOVE_W-1:0]           move_out_reg;

    // Combinational helpers
    logic [csg_pkg::LEN_W-1:0]            in_len;
    logic [csg_pkg::PAYLOAD_W-1:0]        in_payload;
    logic [csg_pkg::PAYLOAD_W-1:0]        word_masked;
    logic [csg_pkg::PAYLOAD_W-1:0]        shifted;
    logic [31:0]                          wmask;
    logic [31:0]                          raw;
    logic                                 sbit;
    logic [70:0]                          x100;
    logic signed [55:0]                   min56;
    logic signed [55:0]                   max56;
    logic [csg_pkg::ANGLE_W-1:0]          amin;
    logic [csg_pkg::ANGLE_W-1:0]          amax;
    logic signed [9:0]                    adiff;
    logic signed [17:0]                   amin100;
    logic signed [17:0]                   qsigned;
    logic                                 div_start;
    logic [csg_pkg::DIV_NUM_W-1:0]        div_num;
    logic [csg_pkg::DIV_DEN_W-1:0]        div_den;
    logic                                 div_busy;
    logic [csg_pkg::DIV_QW-1:0]           div_quo;
    logic [csg_pkg::TARGET_W-1:0]         tgt;

    assign in_len     = s_tdata[csg_pkg::LEN_W-1:0];
    assign in_payload = s_tdata[csg_pkg::LEN_W +: csg_pkg::PAYLOAD_W];

    // Drop payload bytes at or above the length code
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            word_masked[b*8 +: 8] = (in_len > 4'(b)) ? in_payload[b*8 +: 8] : 8'h00;
        end
    end

    // Field extraction with optional sign extension
    assign shifted = word_reg >> cfg.field_start;
    assign wmask   = (32'd1 << cfg.field_width) - 32'd1;
    assign raw     = shifted[31:0] & wmask;
    assign sbit    = (cfg.field_width != 5'd0) &&
                     ((raw & (32'd1 << (cfg.field_width - 5'd1))) != 32'd0);

    // |p| * 100 by shift-add
    assign x100 = ({7'd0, pabs_reg} << 6) + ({7'd0, pabs_reg} << 5) + ({7'd0, pabs_reg} << 2);

    assign min56 = {{24{cfg.value_min_h[31]}}, cfg.value_min_h};
    assign max56 = {{24{cfg.value_max_h[31]}}, cfg.value_max_h};

    // Angle limits, each saturated to the dial's range
    assign amin = (cfg.angle_limits[8:0] > csg_pkg::ANGLE_W'(MAX_ANGLE))
                ? csg_pkg::ANGLE_W'(MAX_ANGLE) : cfg.angle_limits[8:0];
    assign amax = (cfg.angle_limits[17:9] > csg_pkg::ANGLE_W'(MAX_ANGLE))
                ? csg_pkg::ANGLE_W'(MAX_ANGLE) : cfg.angle_limits[17:9];
    assign adiff   = $signed({1'b0, amax}) - $signed({1'b0, amin});
    assign amin100 = $signed(18'({9'd0, amin}) * 18'(csg_pkg::HUNDREDTHS));
    assign qsigned = qneg_reg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});

    // Shared divider operands
    assign div_start = (op == csg_pkg::OP_DIV1_START) || (op == csg_pkg::OP_DIV2_START);
    assign div_num   = (op == csg_pkg::OP_DIV1_START) ? nmag_reg
                                                      : csg_pkg::DIV_NUM_W'(tnum_reg);
    assign div_den   = (op == csg_pkg::OP_DIV1_START) ? dmag_reg
                                                      : csg_pkg::DIV_DEN_W'(csg_pkg::TGT_DIVISOR);

    csg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    // Rounded step target, limited to full scale
    always_comb begin
        if (azero_reg) begin
            tgt = '0;
        end else if (div_quo > csg_pkg::DIV_QW'(FULL_SCALE_STEPS)) begin
            tgt = csg_pkg::TARGET_W'(FULL_SCALE_STEPS);
        end else begin
            tgt = div_quo[csg_pkg::TARGET_W-1:0];
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;
        if (op == csg_pkg::OP_FINISH) m_tvalid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            needle_reg   <= '0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (op == csg_pkg::OP_FINISH) needle_reg <= tgt;
        end
        case (op)
            csg_pkg::OP_LOAD: begin
                match_reg <= (s_tuser == cfg.frame_id);
                word_reg  <= word_masked;
            end
            csg_pkg::OP_EXTRACT: begin
                val_reg <= $signed((cfg.value_min_h[31] && sbit) ? (raw | ~wmask) : raw);
            end
            csg_pkg::OP_MUL: prod_reg <= val_reg * cfg.gain_q16;
            csg_pkg::OP_ADD: begin
                p_reg <= prod_reg + $signed({{32{cfg.value_offset[15]}}, cfg.value_offset, 16'h0});
            end
            csg_pkg::OP_ABS: begin
                pneg_reg <= p_reg[63];
                pabs_reg <= p_reg[63] ? 64'(-p_reg) : p_reg;
            end
            csg_pkg::OP_SCALE: hmag_reg <= x100[70:16];
            csg_pkg::OP_SIGN: begin
                h_reg <= pneg_reg ? -$signed({1'b0, hmag_reg}) : $signed({1'b0, hmag_reg});
            end
            csg_pkg::OP_CLAMP: begin
                if (h_reg < min56) begin
                    hc_reg <= cfg.value_min_h;
                end else if (h_reg > max56) begin
                    hc_reg <= cfg.value_max_h;
                end else begin
                    hc_reg <= h_reg[31:0];
                end
            end
            csg_pkg::OP_SPAN: begin
                diff_reg <= $signed({hc_reg[31], hc_reg})
                          - $signed({cfg.value_min_h[31], cfg.value_min_h});
                dsub_reg <= $signed({cfg.value_max_h[31], cfg.value_max_h})
                          - $signed({cfg.value_min_h[31], cfg.value_min_h});
                span_reg <= 17'(adiff) * 17'sd100;
                eq_reg   <= (cfg.value_max_h == cfg.value_min_h);
            end
            csg_pkg::OP_NUM: begin
                num_reg  <= diff_reg * span_reg;
                dneg_reg <= dsub_reg[32];
                dmag_reg <= dsub_reg[32] ? csg_pkg::DIV_DEN_W'(-dsub_reg)
                                         : dsub_reg[csg_pkg::DIV_DEN_W-1:0];
            end
            csg_pkg::OP_NABS: begin
                qneg_reg <= num_reg[49] ^ dneg_reg;
                nmag_reg <= num_reg[49] ? csg_pkg::DIV_NUM_W'(-num_reg)
                                        : num_reg[csg_pkg::DIV_NUM_W-1:0];
            end
            csg_pkg::OP_MAP: a_reg <= eq_reg ? amin100 : (qsigned + amin100);
            csg_pkg::OP_TSCALE: begin
                azero_reg <= (a_reg <= 18'sd0);
                tnum_reg  <= 32'(a_reg[16:0]) * 32'(STEPS_PER_REV) + 32'(csg_pkg::TGT_ROUND);
            end
            csg_pkg::OP_FINISH: begin
                tgt_out_reg  <= tgt;
                move_out_reg <= {1'b0, tgt} - {1'b0, needle_reg};
            end
            default: ;
        endcase
    end

    assign stat.match    = match_reg;
    assign stat.div_busy = div_busy;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, move_out_reg, tgt_out_reg};

endmodule

>>> hw/rtl/can_signal_to_gauge_steps.sv
// Top level of the CAN signal to gauge step converter: configuration registers and wiring.
// A frame whose id does not match gives no result. Throughput: one frame at a time; the
// two passes through the shared divider (angle map, then step rounding) dominate a frame.
// Reset (aresetn low, synchronous): configuration returns to defaults, needle position
// homes to 0, any frame in flight and any pending result beat are dropped.
module can_signal_to_gauge_steps #(
    parameter int FULL_SCALE_STEPS = 630,
    parameter int MAX_ANGLE        = 315,
    parameter int STEPS_PER_REV    = 720
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [csg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Frame stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [csg_pkg::S_TDATA_W-1:0]      s_tdata,   // [3:0] msg_len, [67:4] payload
    input  logic [csg_pkg::ID_W-1:0]           s_tuser,   // [31:0] msg_id
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [csg_pkg::M_TDATA_W-1:0]      m_tdata    // [9:0] target_step, [20:10] step_move
);

    csg_pkg::cfg_t    cfg_reg, cfg_next;
    csg_pkg::op_t     op;
    csg_pkg::status_t stat;

    // Register writes: take the low bits of the write data for each register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                csg_pkg::REG_FRAME_ID:     cfg_next.frame_id     = cfg_wdata;
                csg_pkg::REG_FIELD_START:  cfg_next.field_start  = cfg_wdata[5:0];
                csg_pkg::REG_FIELD_WIDTH:  cfg_next.field_width  = cfg_wdata[4:0];
                csg_pkg::REG_GAIN_Q16:     cfg_next.gain_q16     = $signed(cfg_wdata);
                csg_pkg::REG_VALUE_OFFSET: cfg_next.value_offset = $signed(cfg_wdata[15:0]);
                csg_pkg::REG_VALUE_MIN_H:  cfg_next.value_min_h  = $signed(cfg_wdata);
                csg_pkg::REG_VALUE_MAX_H:  cfg_next.value_max_h  = $signed(cfg_wdata);
                csg_pkg::REG_ANGLE_LIMITS: cfg_next.angle_limits = cfg_wdata[17:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_id     <= 32'd0;
            cfg_reg.field_start  <= 6'd0;
            cfg_reg.field_width  <= 5'd8;
            cfg_reg.gain_q16     <= 32'sd65536;
            cfg_reg.value_offset <= 16'sd0;
            cfg_reg.value_min_h  <= 32'sd0;
            cfg_reg.value_max_h  <= 32'sd0;
            cfg_reg.angle_limits <= 18'd161280;   // minimum 0 degrees, maximum 315
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: accepts one frame beat, then walks the datapath stages
    csg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .op       (op)
    );

    // Datapath: holds the frame, the arithmetic stages, the needle position and the result beat
    csg_dpath #(
        .FULL_SCALE_STEPS (FULL_SCALE_STEPS),
        .MAX_ANGLE        (MAX_ANGLE),
        .STEPS_PER_REV    (STEPS_PER_REV)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .stat     (stat)
    );

endmodule

>>> hw/rtl/csg_check.sv
// Port-level checks for the CAN signal to gauge step converter, bound to the top level.
module csg_check #(
    parameter int FULL_SCALE_STEPS = 630
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [csg_pkg::M_TDATA_W-1:0]  m_tdata
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // One frame at a time: the input closes right after a beat is taken
    a_one_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still open after accepting a frame");

    // Target stays on the dial
    a_target_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:0] <= 10'(FULL_SCALE_STEPS))
        else $error("target step beyond full scale");

    // The move never exceeds the target, since the previous position is not negative
    a_move_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[20:10]) <= $signed({1'b0, m_tdata[9:0]}))
        else $error("step move larger than target");

endmodule

bind can_signal_to_gauge_steps csg_check #(
    .FULL_SCALE_STEPS (FULL_SCALE_STEPS)
) u_csg_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/can_signal_to_gauge_steps_tb.sv
// Self-checking testbench for can_signal_to_gauge_steps: directed probes, then random frames.
`timescale 1ns / 100ps

module can_signal_to_gauge_steps_tb;
    import csg_pkg::*;

    localparam int FULL_SCALE_STEPS = 630;
    localparam int MAX_ANGLE        = 315;
    localparam int STEPS_PER_REV    = 720;

    localparam longint Q16_ONE          = 65536;
    localparam int     DRAIN_CYCLES     = 64;
    localparam int     WATCHDOG_LIMIT   = 2000;   // cycles with no beat on either side
    localparam int     RAND_PHASES      = 16;
    localparam int     FRAMES_PER_PHASE = 106;
    localparam int     QUIET_PHASE      = 13;     // from this phase on nobody idles
    localparam int     MAX_REPORTS      = 100;

    // One gauge update: absolute target and signed move from the last position
    typedef struct packed {
        logic        [TARGET_W-1:0] target;
        logic signed [MOVE_W-1:0]   move;
    } gauge_move_t;

    // One directed probe: frame, register set it runs under, optional typed-in result
    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] payload;
        logic [2:0]           setup;
        logic                 typed;
        gauge_move_t          want;
    } frame_probe_t;

    localparam cfg_t CFG_AT_RESET = '{32'd0, 6'd0, 5'd8, 32'sd65536, 16'sd0, 32'sd0, 32'sd0,
                                      18'd161280};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [ID_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // Shadow of the block: register contents and needle position
    cfg_t                  gauge_cfg  = CFG_AT_RESET;
    logic [TARGET_W-1:0]   needle_pos = '0;
    gauge_move_t           pending_moves[$];

    bit send_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    int frames_sent;
    int moves_checked;
    int cfg_loads;
    int mismatches;
    int quiet_cycles;

    // Register sets for the directed part; set 0 is what reset leaves behind
    cfg_t probe_setups[5] = '{
        CFG_AT_RESET,
        // plain unsigned 16-bit field, 0..100.00 over the full sweep
        '{32'h18FE_F100, 6'd0, 5'd16, 32'sd65536, 16'sd0, 32'sd0, 32'sd10000, 18'd161280},
        // field hanging off the top of the word, negative gain, angle field above range
        '{32'h0000_07FF, 6'd60, 5'd16, -32'sd65536, 16'sh8000, -32'sd500000, 32'sd500000,
          18'd204820},
        // zero width, register extremes, reversed angle range
        '{32'hFFFF_FFFF, 6'd63, 5'd0, 32'sh7FFF_FFFF, 16'sh7FFF, 32'sh8000_0000,
          32'sh7FFF_FFFF, 18'd315},
        // crossed value limits, widest field, most negative gain
        '{32'h0000_0123, 6'd5, 5'd31, 32'sh8000_0000, 16'sd0, 32'sd1000, -32'sd1000,
          18'd102500}
    };

    // Under set 1, typed results follow from value v landing on round(v * 6.3) steps
    frame_probe_t probe_rows[21] = '{
        '{32'h0000_0000, 4'd8,  64'h0000_0000_0000_00FF, 3'd0, 1'b1, {10'd0, 11'sd0}},
        '{32'h0000_0001, 4'd8,  64'h0,                   3'd0, 1'b0, '0},
        '{32'h18FE_F100, 4'd2,  64'd100,                 3'd1, 1'b1, {10'd630, 11'sd630}},
        '{32'h18FE_F100, 4'd2,  64'd0,                   3'd1, 1'b1, {10'd0, -11'sd630}},
        '{32'h18FE_F100, 4'd2,  64'h0000_0000_0000_FFFF, 3'd1, 1'b1, {10'd630, 11'sd630}},
        '{32'h18FE_F100, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 3'd1, 1'b1, {10'd0, -11'sd630}},
        '{32'h18FE_F100, 4'd15, 64'd50,                  3'd1, 1'b0, '0},
        '{32'h18FE_F101, 4'd8,  64'd50,                  3'd1, 1'b0, '0},
        '{32'hFFFF_FFFF, 4'd8,  64'd50,                  3'd1, 1'b0, '0},
        '{32'h18FE_F100, 4'd8,  64'h0123_4567_89AB_0021, 3'd1, 1'b0, '0},
        '{32'h18FE_F100, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 3'd1, 1'b0, '0},
        '{32'h0000_07FF, 4'd8,  64'hFFFF_0000_0000_0000, 3'd2, 1'b0, '0},
        '{32'h0000_07FF, 4'd3,  64'hFFFF_FFFF_FFFF_FFFF, 3'd2, 1'b0, '0},
        '{32'h0000_07FF, 4'd8,  64'h8000_0000_0000_0000, 3'd2, 1'b0, '0},
        '{32'h0000_07FE, 4'd8,  64'h0,                   3'd2, 1'b0, '0},
        '{32'hFFFF_FFFF, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 3'd3, 1'b0, '0},
        '{32'hFFFF_FFFF, 4'd0,  64'h0,                   3'd3, 1'b0, '0},
        '{32'hFFFF_FFFE, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 3'd3, 1'b0, '0},
        '{32'h0000_0123, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 3'd4, 1'b0, '0},
        '{32'h0000_0123, 4'd8,  64'h0,                   3'd4, 1'b0, '0},
        '{32'h0000_0123, 4'd8,  64'h0000_0000_0000_0020, 3'd4, 1'b0, '0}
    };

    can_signal_to_gauge_steps #(
        .FULL_SCALE_STEPS (FULL_SCALE_STEPS),
        .MAX_ANGLE        (MAX_ANGLE),
        .STEPS_PER_REV    (STEPS_PER_REV)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Work out the gauge move a frame causes, advancing the shadow needle.
    // Returns 0 when the frame id does not match and nothing comes out.
    function automatic bit predict_move(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                                        input logic [PAYLOAD_W-1:0] payload,
                                        output gauge_move_t res);
        logic [63:0] word;
        logic [63:0] raw;
        int          nbytes;
        longint      val, prod, quo, rem, hund, lo, hi, amin, amax, ang, tgt;
        res = '0;
        if (id != gauge_cfg.frame_id) begin
            return 1'b0;
        end
        // bytes at and above the length code read as zero; codes above 8 mean 8
        nbytes = (len > 4'd8) ? 8 : int'(len);
        word   = (nbytes == 8) ? payload : payload & ((64'd1 << (8 * nbytes)) - 64'd1);
        lo     = longint'($signed(gauge_cfg.value_min_h));
        hi     = longint'($signed(gauge_cfg.value_max_h));
        if (gauge_cfg.field_width == 5'd0) begin
            val = 0;
        end else begin
            raw = (word >> gauge_cfg.field_start)
                  & ((64'd1 << gauge_cfg.field_width) - 64'd1);
            val = longint'(raw);
            // a negative lower limit means the field is two's complement
            if (lo < 0 && raw[gauge_cfg.field_width - 1]) begin
                val = val - (longint'(1) << gauge_cfg.field_width);
            end
        end
        // Q16.16 product plus offset, then truncate toward zero to hundredths
        prod = val * longint'($signed(gauge_cfg.gain_q16))
               + longint'($signed(gauge_cfg.value_offset)) * Q16_ONE;
        quo  = prod / Q16_ONE;
        rem  = prod - quo * Q16_ONE;
        hund = quo * HUNDREDTHS + (rem * HUNDREDTHS) / Q16_ONE;
        // lower limit wins first, which settles crossed limits
        if (hund < lo) begin
            hund = lo;
        end else if (hund > hi) begin
            hund = hi;
        end
        amin = (gauge_cfg.angle_limits[8:0] > MAX_ANGLE) ?
               longint'(MAX_ANGLE) : longint'(gauge_cfg.angle_limits[8:0]);
        amax = (gauge_cfg.angle_limits[17:9] > MAX_ANGLE) ?
               longint'(MAX_ANGLE) : longint'(gauge_cfg.angle_limits[17:9]);
        if (hi == lo) begin
            ang = amin * HUNDREDTHS;
        end else begin
            ang = (hund - lo) * ((amax - amin) * HUNDREDTHS) / (hi - lo) + amin * HUNDREDTHS;
        end
        // angle in hundredths of a degree to steps, rounding half up
        if (ang <= 0) begin
            tgt = 0;
        end else begin
            tgt = (ang * STEPS_PER_REV + TGT_ROUND) / TGT_DIVISOR;
            if (tgt > FULL_SCALE_STEPS) begin
                tgt = FULL_SCALE_STEPS;
            end
        end
        res.target = TARGET_W'(tgt);
        res.move   = MOVE_W'(tgt - longint'(needle_pos));
        needle_pos = TARGET_W'(tgt);
        return 1'b1;
    endfunction

    // Random register set, mostly one whose limits sit inside the reachable values
    function automatic cfg_t draw_cfg();
        cfg_t        c;
        longint      gmag, reach;
        int unsigned reach_u;
        c.frame_id    = $urandom;
        c.field_width = ($urandom_range(0, 15) == 0) ? 5'd0 :
                        ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31)) :
                                                       5'($urandom_range(1, 16));
        c.field_start = ($urandom_range(0, 4) == 0) ? 6'($urandom) :
                        6'($urandom_range(0, 64 - int'(c.field_width)));
        case ($urandom_range(0, 3))
            0: c.gain_q16 = $urandom;
            1: c.gain_q16 = 32'(-longint'($urandom_range(1, 1 << 20)));
            default: c.gain_q16 = $urandom_range(1 << 12, 1 << 20);
        endcase
        c.value_offset = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                         16'($urandom_range(0, 200)) - 16'sd100;
        gmag  = ($signed(c.gain_q16) < 0) ? -longint'($signed(c.gain_q16)) :
                longint'($signed(c.gain_q16));
        reach = ((longint'(1) << c.field_width) * gmag / Q16_ONE + 32768) * HUNDREDTHS;
        if (reach > 64'sh7FFF_FFFF) begin
            reach = 64'sh7FFF_FFFF;
        end
        reach_u = int'(reach);
        case ($urandom_range(0, 7))
            0: begin
                c.value_min_h = $urandom;
                c.value_max_h = $urandom;
            end
            1: begin
                c.value_min_h = $urandom_range(0, reach_u);
                c.value_max_h = c.value_min_h;
            end
            2, 3, 4: begin
                c.value_min_h = 32'(-longint'($urandom_range(1, reach_u)));
                c.value_max_h = $urandom_range(0, reach_u);
            end
            default: begin
                c.value_min_h = $urandom_range(0, reach_u / 8);
                c.value_max_h = $urandom_range(reach_u / 8 + 1, reach_u);
            end
        endcase
        case ($urandom_range(0, 3))
            0: c.angle_limits = 18'($urandom);
            1: c.angle_limits = {9'($urandom_range(0, 315)), 9'($urandom_range(0, 315))};
            default: c.angle_limits = {9'($urandom_range(150, 315)), 9'($urandom_range(0, 149))};
        endcase
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Write all eight registers back to back; enable stays high across them
    task automatic load_cfg(input cfg_t c);
        write_reg(REG_FRAME_ID,     c.frame_id);
        write_reg(REG_FIELD_START,  32'(c.field_start));
        write_reg(REG_FIELD_WIDTH,  32'(c.field_width));
        write_reg(REG_GAIN_Q16,     c.gain_q16);
        write_reg(REG_VALUE_OFFSET, 32'(c.value_offset));
        write_reg(REG_VALUE_MIN_H,  c.value_min_h);
        write_reg(REG_VALUE_MAX_H,  c.value_max_h);
        write_reg(REG_ANGLE_LIMITS, 32'(c.angle_limits));
        cfg_wr_en <= 1'b0;
        gauge_cfg = c;
        cfg_loads++;
    endtask

    // Drop valid, wait for every pending move, then give a non-matching frame time to clear
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_moves.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Present one frame beat and hold it until accepted; returns at the accepting edge
    task automatic send_frame(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                              input logic [PAYLOAD_W-1:0] payload, input bit typed,
                              input gauge_move_t typed_move);
        gauge_move_t res;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= id;
        s_tdata  <= {4'd0, payload, len};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        frames_sent++;
        // the shadow needle must advance on typed rows too
        if (predict_move(id, len, payload, res)) begin
            pending_moves.push_back(typed ? typed_move : res);
        end
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Result side: ready drops in random bursts while gaps are allowed
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (sink_gaps && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest pending move, field by field
    always @(posedge aclk) begin : move_checker
        gauge_move_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_moves.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result beat with nothing pending, target %0d move %0d",
                             $time, m_tdata[9:0], $signed(m_tdata[20:10]));
                end
            end else begin
                want = pending_moves.pop_front();
                moves_checked++;
                if (m_tdata[9:0] !== want.target) begin
                    report_mismatch("target_step", longint'(want.target),
                                    longint'(m_tdata[9:0]));
                end
                if (m_tdata[20:10] !== want.move) begin
                    report_mismatch("step_move", longint'(want.move),
                                    longint'($signed(m_tdata[20:10])));
                end
            end
        end
    end

    // Stop a hung run: too long with no beat on either side
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d moves still pending", $time,
                     WATCHDOG_LIMIT, pending_moves.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        logic [2:0]      setup_now;
        cfg_t            phase_cfg;
        logic [ID_W-1:0] id;
        logic [LEN_W-1:0] len;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed probes: reset state first, then each special register set
        setup_now = 3'd0;
        foreach (probe_rows[i]) begin
            if (probe_rows[i].setup != setup_now) begin
                settle();
                setup_now = probe_rows[i].setup;
                load_cfg(probe_setups[setup_now]);
            end
            send_frame(probe_rows[i].id, probe_rows[i].len, probe_rows[i].payload,
                       probe_rows[i].typed, probe_rows[i].want);
        end

        // Random phases, each under a fresh register set; the first two are the extremes
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            case (ph)
                0: phase_cfg = '{32'd0, 6'd0, 5'd1, 32'sh8000_0000, 16'sh8000,
                                 32'sh8000_0000, 32'sd0, 18'd0};
                1: phase_cfg = '{32'hFFFF_FFFF, 6'd63, 5'd31, 32'sh7FFF_FFFF, 16'sh7FFF,
                                 32'sd0, 32'sh7FFF_FFFF, 18'h3FFFF};
                default: phase_cfg = draw_cfg();
            endcase
            load_cfg(phase_cfg);
            // every fourth phase runs flat out; the tail of the run never idles
            send_gaps = (ph < QUIET_PHASE) && (ph % 4 != 3);
            sink_gaps = send_gaps;
            repeat (FRAMES_PER_PHASE) begin
                // mostly frames for this gauge; the rest foreign or one bit off
                case ($urandom_range(0, 9))
                    0: id = $urandom;
                    1: id = gauge_cfg.frame_id ^ (32'd1 << $urandom_range(0, 31));
                    default: id = gauge_cfg.frame_id;
                endcase
                len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
                send_frame(id, len, {$urandom, $urandom}, 1'b0, '0);
            end
        end

        settle();
        $display("covered %0d frames under %0d register sets, %0d gauge moves checked",
                 frames_sent, cfg_loads, moves_checked);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/csg_pkg.sv
hw/rtl/csg_div.sv
hw/rtl/csg_ctrl.sv
hw/rtl/csg_dpath.sv
hw/rtl/can_signal_to_gauge_steps.sv
hw/rtl/csg_check.sv
bench/can_signal_to_gauge_steps_tb.sv
